/* design/mcbm_pkg.sv */
// ============================================================================
// mcbm_pkg
// Shared types and constants for the multi-mode cartridge bank mapper.
// ============================================================================
`default_nettype none
package mcbm_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  data;
    } mcbm_in_t;

    typedef struct packed {
        logic [8:0] bank;
        logic [1:0] mirroring;
        logic [2:0] irq_action;
        logic [7:0] irq_latch_value;
    } mcbm_out_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_PRG   = 2'd1,
        KIND_CHR   = 2'd2,
        KIND_NONE  = 2'd3
    } mcbm_kind_t;

    typedef enum logic [2:0] {
        IRQ_NONE    = 3'd0,
        IRQ_LATCH   = 3'd1,
        IRQ_RELOAD  = 3'd2,
        IRQ_ENABLE  = 3'd3,
        IRQ_DISABLE = 3'd4
    } mcbm_irq_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_FULL = 1'b1
    } mcbm_state_t;

    localparam logic [0:0] CFG_PRG_MAX = 1'b0;
    localparam logic [0:0] CFG_CHR_MAX = 1'b1;

    typedef struct packed {
        logic load;
    } mcbm_cmd_t;

    typedef struct packed {
        logic unused;
    } mcbm_status_t;

endpackage
`default_nettype wire

/* design/mcbm_ctrl.sv */
// ============================================================================
// mcbm_ctrl
// Output handshake controller: load an item when the result slot is empty or frees.
// ============================================================================
`default_nettype none
module mcbm_ctrl
    import mcbm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    output mcbm_cmd_t cmd
);
    mcbm_state_t state_reg, state_next;
    logic        take;

    always_comb
    begin
        take = in_valid && (state_reg == ST_IDLE || !out_stall);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (take) state_next = ST_FULL;
            ST_FULL: if (!out_stall && !take) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg == ST_FULL) && out_stall;
        out_valid = (state_reg == ST_FULL);
        cmd.load  = take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid) else $error("load without result");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall)) else $error("bad stall");
endmodule
`default_nettype wire

/* design/mcbm_datapath.sv */
// ============================================================================
// mcbm_datapath
// Mapper registers, bank translation and the result register.
// ============================================================================
`default_nettype none
module mcbm_datapath
    import mcbm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire mcbm_cmd_t  cmd,
    input  wire mcbm_in_t   item,
    input  wire logic       cfg_we,
    input  wire logic [0:0] cfg_index,
    input  wire logic [8:0] cfg_data,
    output mcbm_out_t       result
);
    logic [7:0] prg_max_reg;
    logic [8:0] chr_max_reg;
    logic [7:0] pers_reg, pers_next;
    logic [7:0] appl_reg, appl_next;
    logic [4:0] vprg_reg [2];
    logic [4:0] vprg_next [2];
    logic [7:0] vchr_reg [8];
    logic [7:0] vchr_next [8];
    logic       vmir_reg, vmir_next;
    logic [7:0] m3c_reg, m3c_next;
    logic [7:0] m3m_reg, m3m_next;
    logic [7:0] m3b_reg [10];
    logic [7:0] m3b_next [10];
    logic [4:0] m1r_reg [4];
    logic [4:0] m1r_next [4];
    logic [4:0] sbuf_reg, sbuf_next;
    logic [2:0] scnt_reg, scnt_next;
    mcbm_out_t  res_reg, res_next;

    logic [15:0] a;
    logic [7:0]  v;
    logic [1:0]  p;
    logic [3:0]  rg;
    logic [2:0]  act;
    logic [7:0]  lat;
    logic [1:0]  pslot;
    logic [2:0]  cslot;
    logic [8:0]  bank;
    logic [1:0]  mir;
    logic [8:0]  t9;
    logic [8:0]  base;
    logic [2:0]  cidx;
    logic [4:0]  sb;
    logic [2:0]  r;
    logic [8:0]  lim;

    always_comb
    begin
        a     = item.address;
        v     = item.data;
        p     = pers_reg[1:0];
        rg    = a[15:12];
        pslot = a[14:13];
        cslot = a[12:10];
        act   = IRQ_NONE;
        lat   = 8'd0;
        pers_next = pers_reg;
        appl_next = appl_reg;
        vprg_next = vprg_reg;
        vchr_next = vchr_reg;
        vmir_next = vmir_reg;
        m3c_next  = m3c_reg;
        m3m_next  = m3m_reg;
        m3b_next  = m3b_reg;
        m1r_next  = m1r_reg;
        sbuf_next = sbuf_reg;
        scnt_next = scnt_reg;
        cidx = 3'd0;
        sb   = 5'd0;
        r    = m3c_reg[2:0];
        t9   = 9'd0;
        lim  = 9'd0;
        if (item.mode == KIND_WRITE && a >= 16'h4100)
        begin
            if (a < 16'h6000 && a[8])
            begin
                if (pers_reg != v)
                begin
                    pers_next = v;
                    if (!v[0]) act = IRQ_DISABLE;
                    if (v[1:0] != 2'd3) appl_next = v;
                end
            end
            else if (a[15])
            begin
                case (p)
                    2'd0:
                    begin
                        if (rg == 4'h8 || rg == 4'hA)
                            vprg_next[a[13]] = v[4:0];
                        else if (rg == 4'h9)
                            vmir_next = v[0];
                        else if (rg >= 4'hB && rg <= 4'hE)
                        begin
                            t9   = {1'b0, 4'(rg - 4'hB), 4'd0};
                            cidx = {t9[5:4], a[0]};
                            vchr_next[cidx] = a[1] ? {v[3:0], 4'd0} : {4'd0, v[3:0]};
                        end
                    end
                    2'd1:
                    begin
                        if (rg <= 4'h9)
                        begin
                            if (a[0])
                            begin
                                if (r < 3'd2) m3b_next[{1'b0, r}] = {1'b0, v[7:1]};
                                else          m3b_next[{1'b0, r}] = v;
                            end
                            else
                                m3c_next = v;
                        end
                        else if (rg <= 4'hB)
                        begin
                            if (!a[0]) m3m_next = v;
                        end
                        else if (rg <= 4'hD)
                        begin
                            if (a[0]) act = IRQ_RELOAD;
                            else
                            begin
                                act = IRQ_LATCH;
                                lat = v;
                            end
                        end
                        else
                            act = a[0] ? IRQ_ENABLE : IRQ_DISABLE;
                    end
                    2'd2:
                    begin
                        if (!v[7])
                        begin
                            sb = (scnt_reg < 3'd5) ? (sbuf_reg | (5'(v[0]) << scnt_reg))
                                                   : sbuf_reg;
                            if (scnt_reg == 3'd4)
                            begin
                                m1r_next[a[14:13]] = sb;
                                sbuf_next = 5'd0;
                                scnt_next = 3'd0;
                            end
                            else
                            begin
                                sbuf_next = sb;
                                scnt_next = scnt_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            sbuf_next = 5'd0;
                            scnt_next = 3'd0;
                            m1r_next[0] = m1r_reg[0] | 5'h0C;
                        end
                    end
                    default: ;
                endcase
            end
        end

        // lookup, using state before this item
        bank = 9'd0;
        base = {appl_reg[2], 8'd0};
        if (item.mode == KIND_PRG && a[15])
        begin
            case (appl_reg[1:0])
                2'd0:
                begin
                    t9 = (pslot == 2'd0) ? 9'(vprg_reg[0]) : (pslot == 2'd1) ? 9'(vprg_reg[1])
                       : (pslot == 2'd2) ? 9'h1E : 9'h1F;
                    lim = {1'b0, prg_max_reg};
                    bank = (t9 > lim) ? (t9 & lim) : t9;
                end
                2'd1:
                begin
                    case (pslot)
                        2'd0: t9 = m3c_reg[6] ? 9'(m3b_reg[8]) : 9'(m3b_reg[6]);
                        2'd1: t9 = 9'(m3b_reg[7]);
                        2'd2: t9 = m3c_reg[6] ? 9'(m3b_reg[6]) : 9'(m3b_reg[8]);
                        default: t9 = 9'(m3b_reg[9]);
                    endcase
                    lim = {1'b0, prg_max_reg};
                    bank = (t9 > lim) ? (t9 & lim) : t9;
                end
                default:
                begin
                    if (m1r_reg[0][3])
                    begin
                        if (!pslot[1]) t9 = m1r_reg[0][2] ? 9'(m1r_reg[3][3:0]) : 9'd0;
                        else           t9 = m1r_reg[0][2] ? 9'h0F : 9'(m1r_reg[3][3:0]);
                        lim = {2'd0, prg_max_reg[7:1]};
                        t9 = (t9 > lim) ? (t9 & lim) : t9;
                        bank = {t9[7:0], pslot[0]};
                    end
                    else
                    begin
                        t9 = 9'(m1r_reg[3][3:1]);
                        lim = {3'd0, prg_max_reg[7:2]};
                        t9 = (t9 > lim) ? (t9 & lim) : t9;
                        bank = {t9[6:0], pslot};
                    end
                end
            endcase
        end
        else if (item.mode == KIND_CHR)
        begin
            case (appl_reg[1:0])
                2'd0:
                begin
                    t9 = base | 9'(vchr_reg[cslot]);
                    bank = (t9 > chr_max_reg) ? (t9 & chr_max_reg) : t9;
                end
                2'd1:
                begin
                    if (cslot[2] == m3c_reg[7])
                    begin
                        t9 = (base >> 1) | 9'(m3b_reg[{3'd0, cslot[1]}]);
                        lim = {1'b0, chr_max_reg[8:1]};
                        t9 = (t9 > lim) ? (t9 & lim) : t9;
                        bank = {t9[7:0], cslot[0]};
                    end
                    else
                    begin
                        t9 = base | 9'(m3b_reg[4'(cslot[1:0]) + 4'd2]);
                        bank = (t9 > chr_max_reg) ? (t9 & chr_max_reg) : t9;
                    end
                end
                default:
                begin
                    if (!cslot[2]) t9 = m1r_reg[0][4] ? 9'(m1r_reg[1]) : 9'(m1r_reg[1] & 5'h1E);
                    else           t9 = m1r_reg[0][4] ? 9'(m1r_reg[2]) : 9'(m1r_reg[1] | 5'h01);
                    lim = {2'd0, chr_max_reg[8:2]};
                    t9 = (t9 > lim) ? (t9 & lim) : t9;
                    bank = {t9[6:0], cslot[1:0]};
                end
            endcase
        end

        // mirroring reflects state after this item
        case (appl_next[1:0])
            2'd0: mir = {1'b0, vmir_next};
            2'd1: mir = {1'b0, m3m_next[0]};
            default:
                case (m1r_next[0][1:0])
                    2'd0: mir = 2'd2;
                    2'd1: mir = 2'd3;
                    2'd2: mir = 2'd0;
                    default: mir = 2'd1;
                endcase
        endcase

        res_next.bank            = bank;
        res_next.mirroring       = mir;
        res_next.irq_action      = act;
        res_next.irq_latch_value = lat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_max_reg <= 8'hFF;
            chr_max_reg <= 9'h1FF;
            pers_reg <= 8'd0;
            appl_reg <= 8'd0;
            vprg_reg <= '{5'd0, 5'd1};
            vchr_reg <= '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7};
            vmir_reg <= 1'b0;
            m3c_reg  <= 8'd0;
            m3m_reg  <= 8'd0;
            m3b_reg  <= '{8'h00, 8'h01, 8'h04, 8'h05, 8'h06, 8'h07,
                          8'h3C, 8'h3D, 8'hFE, 8'hFF};
            m1r_reg  <= '{5'h0C, 5'd0, 5'd0, 5'd0};
            sbuf_reg <= 5'd0;
            scnt_reg <= 3'd0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_PRG_MAX) prg_max_reg <= cfg_data[7:0];
            if (cfg_we && cfg_index == CFG_CHR_MAX) chr_max_reg <= cfg_data;
            if (cmd.load)
            begin
                pers_reg <= pers_next;
                appl_reg <= appl_next;
                vprg_reg <= vprg_next;
                vchr_reg <= vchr_next;
                vmir_reg <= vmir_next;
                m3c_reg  <= m3c_next;
                m3m_reg  <= m3m_next;
                m3b_reg  <= m3b_next;
                m1r_reg  <= m1r_next;
                sbuf_reg <= sbuf_next;
                scnt_reg <= scnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) res_reg <= res_next;
    end

    assign result = res_reg;

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        scnt_reg <= 3'd4) else $error("shift count overrun");
    a_appl: assert property (@(posedge clk) disable iff (!rst_n)
        appl_reg[1:0] != 2'd3) else $error("applied personality 3");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.load) |-> (res_reg.irq_latch_value == 8'd0
                             || res_reg.irq_action == IRQ_LATCH))
        else $error("latch without action");
endmodule
`default_nettype wire

/* design/multi_mode_cartridge_bank_mapper_unit.sv */
// ============================================================================
// multi_mode_cartridge_bank_mapper_unit
// Cartridge bank mapper with three register personalities.
// ============================================================================
// Input items carry a CPU write, a PRG lookup or a CHR lookup and are taken
// when in_valid is high and in_stall low. Every item yields one result item
// on the out channel in the cycle after it is taken, taken when out_valid is
// high and out_stall low. One item per cycle is sustained while the receiver
// does not stall; the single result register holds each result. While the
// receiver stalls, the result holds and in_stall rises, so at most one item
// waits. Reset clears all mapper registers to their power-up values and
// marks the result register empty. Configuration writes (cfg_we, cfg_index,
// cfg_data) set the PRG and CHR bank limits and take effect at the next edge.
// ============================================================================
`default_nettype none
module multi_mode_cartridge_bank_mapper_unit
    import mcbm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire mcbm_in_t   in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output mcbm_out_t       out_data,
    input  wire logic       cfg_we,
    input  wire logic [0:0] cfg_index,
    input  wire logic [8:0] cfg_data
);
    mcbm_cmd_t cmd;

    mcbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    mcbm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (out_data)
    );
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// ============================================================================
// tb_top
// Self-checking bench for the multi-mode cartridge bank mapper.
// ============================================================================
// A table of directed items opens each run, then random write sequences and
// lookups follow across all three personalities. Each result item is checked
// field by field against a behavioural mapper model kept inside the bench.
// The bank limits are changed between phases while the block is idle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import mcbm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    mcbm_in_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    mcbm_out_t out_data;
    logic       cfg_we = 1'b0;
    logic [0:0] cfg_index = CFG_PRG_MAX;
    logic [8:0] cfg_data = '0;

    multi_mode_cartridge_bank_mapper_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // mapper model state
    logic [7:0] m_prg_max;
    logic [8:0] m_chr_max;
    logic [7:0] m_pers;
    logic [7:0] m_applied;
    logic [4:0] m_vprg [2];
    logic [7:0] m_vchr [8];
    logic       m_vmir;
    logic [7:0] m_ctrl;
    logic [7:0] m_mmir;
    logic [7:0] m_mbank [10];
    logic [4:0] m_mmc1 [4];
    logic [4:0] m_shift;
    logic [2:0] m_count;

    mcbm_out_t results_due[$];
    int        fails = 0;
    int        cycles = 0;
    int        send_idle = 0;
    int        recv_idle = 0;
    bit        recv_hold = 1'b0;

    function automatic int clip(int b, int lim);
        return (b > lim) ? (b & lim) : b;
    endfunction

    task automatic mapper_reset();
        int i;
        m_prg_max = 8'hFF;
        m_chr_max = 9'h1FF;
        m_pers = '0;
        m_applied = '0;
        m_vprg[0] = 5'd0;
        m_vprg[1] = 5'd1;
        for (i = 0; i < 8; i++) m_vchr[i] = 8'(i);
        m_vmir = 1'b0;
        m_ctrl = '0;
        m_mmir = '0;
        m_mbank = '{8'h00, 8'h01, 8'h04, 8'h05, 8'h06, 8'h07, 8'h3C, 8'h3D, 8'hFE, 8'hFF};
        m_mmc1 = '{5'h0C, 5'h00, 5'h00, 5'h00};
        m_shift = '0;
        m_count = '0;
    endtask

    function automatic int prg_bank(int slot);
        int p;
        int i;
        int idx;
        int b;
        int v;
        p = m_applied & 3;
        if (p == 0)
        begin
            v = (slot < 2) ? int'(m_vprg[slot]) : (slot == 2 ? 'h1E : 'h1F);
            return clip(v, m_prg_max);
        end
        if (p == 1)
        begin
            i = (m_ctrl >> 5) & 2;
            idx = (slot == 0) ? 6 + i : (slot == 1) ? 7 : (slot == 2) ? 6 + (i ^ 2) : 9;
            return clip(m_mbank[idx], m_prg_max);
        end
        b = m_mmc1[3] & 'hF;
        if (m_mmc1[0][3])
        begin
            if (slot < 2) v = m_mmc1[0][2] ? b : 0;
            else v = m_mmc1[0][2] ? 'hF : b;
            v = clip(v, m_prg_max >> 1);
            return (v << 1) | (slot & 1);
        end
        return (clip(b >> 1, m_prg_max >> 2) << 2) | slot;
    endfunction

    function automatic int chr_bank(int slot);
        int p;
        int base;
        int swp;
        int v;
        p = m_applied & 3;
        base = (m_applied & 4) << 6;
        if (p == 0) return clip(base | m_vchr[slot], m_chr_max);
        if (p == 1)
        begin
            swp = (m_ctrl & 'h80) >> 5;
            if ((slot & 4) == swp)
            begin
                v = (base >> 1) | m_mbank[(slot >> 1) & 1];
                return (clip(v, m_chr_max >> 1) << 1) | (slot & 1);
            end
            return clip(base | m_mbank[2 + (slot & 3)], m_chr_max);
        end
        if (slot < 4) v = m_mmc1[0][4] ? m_mmc1[1] : (m_mmc1[1] & 'h1E);
        else v = m_mmc1[0][4] ? m_mmc1[2] : (m_mmc1[1] | 1);
        return (clip(v, m_chr_max >> 2) << 2) | (slot & 3);
    endfunction

    function automatic logic [1:0] mirror_now();
        int p;
        p = m_applied & 3;
        if (p == 0) return {1'b0, m_vmir};
        if (p == 1) return {1'b0, m_mmir[0]};
        case (m_mmc1[0][1:0])
            2'd0: return 2'd2;
            2'd1: return 2'd3;
            2'd2: return 2'd0;
            default: return 2'd1;
        endcase
    endfunction

    function automatic void apply_write(int a, logic [7:0] v, ref mcbm_out_t r);
        int reg_sel;
        int p;
        int idx;
        int sel;
        if (a < 'h4100) return;
        if (a < 'h6000 && a[8])
        begin
            if (m_pers != v)
            begin
                m_pers = v;
                if (!v[0]) r.irq_action = IRQ_DISABLE;
                if (v[1:0] != 2'd3) m_applied = v;
            end
            return;
        end
        if (a < 'h8000) return;
        reg_sel = (a >> 12) & 'hF;
        p = m_pers & 3;
        if (p == 0)
        begin
            if (reg_sel == 8 || reg_sel == 'hA) m_vprg[(a >> 13) & 1] = v[4:0];
            else if (reg_sel == 9) m_vmir = v[0];
            else if (reg_sel >= 'hB && reg_sel <= 'hE)
            begin
                idx = (((a - 'hB000) >> 11) & 6) | (a & 1);
                m_vchr[idx] = 8'((v & 'hF) << ((a << 1) & 4));
            end
        end
        else if (p == 1)
        begin
            if (reg_sel <= 9)
            begin
                if (a[0])
                begin
                    sel = m_ctrl & 7;
                    m_mbank[sel] = (sel < 2) ? (v >> 1) : v;
                end
                else m_ctrl = v;
            end
            else if (reg_sel <= 'hB)
            begin
                if (!a[0]) m_mmir = v;
            end
            else if (reg_sel <= 'hD)
            begin
                if (a[0]) r.irq_action = IRQ_RELOAD;
                else
                begin
                    r.irq_action = IRQ_LATCH;
                    r.irq_latch_value = v;
                end
            end
            else r.irq_action = a[0] ? IRQ_ENABLE : IRQ_DISABLE;
        end
        else if (p == 2)
        begin
            if (!v[7])
            begin
                m_shift = m_shift | (5'(v[0]) << m_count);
                m_count = m_count + 3'd1;
                if (m_count != 3'd5) return;
                m_mmc1[(a >> 13) & 3] = m_shift;
                m_count = '0;
                m_shift = '0;
            end
            else
            begin
                m_count = '0;
                m_shift = '0;
                m_mmc1[0] = m_mmc1[0] | 5'h0C;
            end
        end
    endfunction

    function automatic mcbm_out_t map_item(mcbm_in_t it);
        mcbm_out_t r;
        r = '0;
        case (it.mode)
            KIND_WRITE: apply_write(it.address, it.data, r);
            KIND_PRG: if (it.address >= 16'h8000) r.bank = 9'(prg_bank((it.address >> 13) & 3));
            KIND_CHR: r.bank = 9'(chr_bank((it.address >> 10) & 7));
            default: ;
        endcase
        r.mirroring = mirror_now();
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        fails++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
        else if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
                report_mismatch("unexpected item", out_data, 0);
            else
            begin
                if (out_data.bank != results_due[0].bank)
                    report_mismatch("bank", out_data.bank, results_due[0].bank);
                if (out_data.mirroring != results_due[0].mirroring)
                    report_mismatch("mirroring", out_data.mirroring, results_due[0].mirroring);
                if (out_data.irq_action != results_due[0].irq_action)
                    report_mismatch("irq_action", out_data.irq_action,
                                    results_due[0].irq_action);
                if (out_data.irq_latch_value != results_due[0].irq_latch_value)
                    report_mismatch("irq_latch", out_data.irq_latch_value,
                                    results_due[0].irq_latch_value);
                void'(results_due.pop_front());
            end
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (recv_hold) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < recv_idle);
    end

    // drive one item and wait for it to be taken
    task automatic send_item(mcbm_in_t it, bit check_given, mcbm_out_t given);
        mcbm_out_t want;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        want = map_item(it);
        if (check_given && want != given)
        begin
            $display("directed row disagrees with model for %h", it);
            fails++;
        end
        results_due.push_back(want);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(logic [0:0] idx, logic [8:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PRG_MAX) m_prg_max = val[7:0];
        else m_chr_max = val;
        @(negedge clk);
    endtask

    function automatic mcbm_in_t mk(mcbm_kind_t k, int a, int d);
        mcbm_in_t it;
        it.mode = k;
        it.address = 16'(a);
        it.data = 8'(d);
        return it;
    endfunction

    function automatic mcbm_out_t res(int b, int m, mcbm_irq_t act, int lat);
        mcbm_out_t r;
        r.bank = 9'(b);
        r.mirroring = 2'(m);
        r.irq_action = act;
        r.irq_latch_value = 8'(lat);
        return r;
    endfunction

    function automatic mcbm_in_t random_item(int pers);
        int a;
        int r;
        mcbm_kind_t k;
        r = $urandom_range(99);
        if (r < 3) return mk(KIND_WRITE, 'h4100 | ($urandom & 'h1EFF), pers);
        if (r < 5) return mk(KIND_NONE, $urandom, $urandom);
        if (r < 8) return mk(KIND_WRITE, $urandom_range('h7FFF), $urandom);
        if (r < 50)
        begin
            a = $urandom_range('h8000, 'hFFFF);
            if (pers == 2 && $urandom_range(9) < 8)
                return mk(KIND_WRITE, a, $urandom & 'h7F);
            return mk(KIND_WRITE, a, $urandom);
        end
        k = (r < 75) ? KIND_PRG : KIND_CHR;
        return mk(k, $urandom, $urandom);
    endfunction

    typedef struct {
        mcbm_in_t  it;
        bit        given;
        mcbm_out_t want;
    } row_t;

    row_t rows[$];

    task automatic random_phase(int count, int s_idle, int r_idle);
        int n;
        int pers;
        send_idle = s_idle;
        recv_idle = r_idle;
        pers = $urandom_range(3);
        send_item(mk(KIND_WRITE, 'h4100, pers), 1'b0, '0);
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(39) == 0)
            begin
                pers = $urandom_range(3);
                if ($urandom_range(3) == 0) pers = pers | ($urandom & 'hFC);
                send_item(mk(KIND_WRITE, 'h4100 | ($urandom & 'h1E00), pers), 1'b0, '0);
            end
            else send_item(random_item(pers & 3), 1'b0, '0);
        end
        drain();
    endtask

    initial
    begin
        mapper_reset();
        rows.push_back('{mk(KIND_PRG, 'h8000, 0), 1, res(0, 0, IRQ_NONE, 0)});
        rows.push_back('{mk(KIND_PRG, 'hA000, 0), 1, res(1, 0, IRQ_NONE, 0)});
        rows.push_back('{mk(KIND_PRG, 'hC000, 0), 1, res('h1E, 0, IRQ_NONE, 0)});
        rows.push_back('{mk(KIND_PRG, 'hFFFF, 'hFF), 1, res('h1F, 0, IRQ_NONE, 0)});
        rows.push_back('{mk(KIND_PRG, 'h7FFF, 0), 1, res(0, 0, IRQ_NONE, 0)});
        rows.push_back('{mk(KIND_CHR, 'hFC00, 0), 1, res(7, 0, IRQ_NONE, 0)});
        rows.push_back('{mk(KIND_NONE, 'hFFFF, 'hFF), 1, res(0, 0, IRQ_NONE, 0)});
        rows.push_back('{mk(KIND_WRITE, 'hB001, 'hFF), 0, '0});
        rows.push_back('{mk(KIND_CHR, 'h0400, 0), 0, '0});
        rows.push_back('{mk(KIND_WRITE, 'h9000, 1), 0, '0});
        rows.push_back('{mk(KIND_WRITE, 'h4100, 0), 1, res(0, 1, IRQ_NONE, 0)});
        rows.push_back('{mk(KIND_WRITE, 'h4100, 1), 1, res(0, 0, IRQ_NONE, 0)});
        rows.push_back('{mk(KIND_WRITE, 'hC000, 'hA5), 1, res(0, 0, IRQ_LATCH, 'hA5)});
        rows.push_back('{mk(KIND_WRITE, 'hC001, 0), 1, res(0, 0, IRQ_RELOAD, 0)});
        rows.push_back('{mk(KIND_WRITE, 'hE001, 0), 1, res(0, 0, IRQ_ENABLE, 0)});
        rows.push_back('{mk(KIND_WRITE, 'hE000, 0), 1, res(0, 0, IRQ_DISABLE, 0)});
        rows.push_back('{mk(KIND_WRITE, 'h8000, 'h80), 0, '0});
        rows.push_back('{mk(KIND_CHR, 'h1000, 0), 0, '0});
        rows.push_back('{mk(KIND_WRITE, 'h5F00, 3), 1, res(0, 0, IRQ_NONE, 0)});
        rows.push_back('{mk(KIND_WRITE, 'hA000, 1), 0, '0});
        rows.push_back('{mk(KIND_WRITE, 'h4100, 6), 1, res(0, 2, IRQ_DISABLE, 0)});
        rows.push_back('{mk(KIND_WRITE, 'hE000, 'h80), 0, '0});
        rows.push_back('{mk(KIND_PRG, 'hE000, 0), 0, '0});
        rows.push_back('{mk(KIND_CHR, 'h1C00, 0), 0, '0});
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (rows[n]) send_item(rows[n].it, rows[n].given, rows[n].want);
        drain();

        random_phase(330, 22, 47);
        write_limit(CFG_PRG_MAX, 9'd0);
        write_limit(CFG_CHR_MAX, 9'd0);
        random_phase(200, 47, 22);
        write_limit(CFG_PRG_MAX, 9'd15);
        write_limit(CFG_CHR_MAX, 9'd127);
        // hold the receiver off so the block fills and stalls its input
        fork
            begin
                recv_hold = 1'b1;
                repeat (60) @(negedge clk);
                recv_hold = 1'b0;
            end
            random_phase(200, 0, 0);
        join
        write_limit(CFG_PRG_MAX, 9'($urandom_range(255)));
        write_limit(CFG_CHR_MAX, 9'($urandom_range(511)));
        random_phase(400, 0, 0);
        write_limit(CFG_PRG_MAX, 9'd255);
        write_limit(CFG_CHR_MAX, 9'd511);
        random_phase(400, 22, 47);

        if (fails == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
design/mcbm_pkg.sv
design/mcbm_ctrl.sv
design/mcbm_datapath.sv
design/multi_mode_cartridge_bank_mapper_unit.sv
tb/tb_top.sv
